// File: rtl/nmac_pkg.sv
// Shared constants and helpers for the alpha compositing pipeline.
`timescale 1ns / 1ps
`default_nettype none
package nmac_pkg;

   localparam int unsigned ChanW   = 16;
   localparam int unsigned QuotW   = 17;
   localparam int unsigned NumW    = 50;
   localparam int unsigned DivW    = 33;
   localparam int unsigned FrontN  = 7;
   localparam int unsigned StageN  = FrontN + QuotW + 1;
   localparam logic [15:0] Unit    = 16'hFFFF;
   localparam logic [47:0] HalfMm  = 48'd2147418112;
   localparam logic [19:0] UnitX1  = 20'd65535;
   localparam logic [19:0] UnitX2  = 20'd131070;
   localparam logic [19:0] UnitX3  = 20'd196605;

   typedef enum logic [7:0] {
      REG_OPACITY  = 8'd0,
      REG_USE_MASK = 8'd1
   } reg_index_type;

   typedef logic [2:0][ChanW-1:0] rgb_type;

   // floor(z / 65535) for z below 2^49
   function automatic logic [33:0] div_m(input logic [NumW-1:0] z);
      logic [33:0] h;
      logic [34:0] w;
      logic [18:0] h2;
      logic [19:0] v;
      logic [1:0]  c;
      h  = z[NumW-1:16];
      w  = {1'b0, h} + {19'd0, z[15:0]};
      h2 = w[34:16];
      v  = {1'b0, h2} + {4'd0, w[15:0]};
      if (v >= UnitX3) begin
         c = 2'd3;
      end else if (v >= UnitX2) begin
         c = 2'd2;
      end else if (v >= UnitX1) begin
         c = 2'd1;
      end else begin
         c = 2'd0;
      end
      return h + {15'd0, h2} + {32'd0, c};
   endfunction

endpackage
`default_nettype wire

// File: rtl/normal_mode_alpha_composite_top.sv
// Straight-alpha over compositing pipeline, top level.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | req_tdata: bottom rgba, top rgba, mask
//  rsp     | out       | rsp_tvalid/tready    | rsp_tdata: out rgba
//  csr     | in        | csr_valid/ready      | csr_index, csr_data
//
// One pixel per clock sustained while rsp_tready is high; a 17-stage
// restoring divider (one quotient bit per stage) follows 7 arithmetic stages.
// Synchronous active-high reset clears all valid bits, sets opacity to full and clears the mask enable.
// Each stage holds while it is full and the stage after it cannot take data;
// empty stages keep filling, so bubbles are squeezed out.
`timescale 1ns / 1ps
`default_nettype none
module normal_mode_alpha_composite_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // bottom_red, bottom_green, bottom_blue, bottom_alpha,
   // top_red, top_green, top_blue, top_alpha, mask_value
   input  wire logic [143:0] req_tdata,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_red, out_green, out_blue, out_alpha
   output      logic [63:0]  rsp_tdata,
   input  wire logic         csr_valid,
   output      logic         csr_ready,
   input  wire logic [7:0]   csr_index,
   input  wire logic [15:0]  csr_data
);

   localparam int unsigned NS = nmac_pkg::StageN;
   localparam int unsigned QW = nmac_pkg::QuotW;
   localparam int unsigned NW = nmac_pkg::NumW;
   localparam int unsigned DW = nmac_pkg::DivW;
   localparam int unsigned FN = nmac_pkg::FrontN;

   logic [15:0]   opacity_ff;
   logic          use_mask_ff;
   logic [NS-1:0] v_ff;
   logic [NS:0]   en;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff  <= nmac_pkg::Unit;
         use_mask_ff <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == nmac_pkg::REG_OPACITY) begin
            opacity_ff <= csr_data;
         end else if (csr_index == nmac_pkg::REG_USE_MASK) begin
            use_mask_ff <= csr_data[0];
         end
      end
   end

   assign en[NS] = rsp_tready;
   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_en
         assign en[k] = rsp_tready | ~(&v_ff[NS-1:k]);
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en[k]) begin
               if (k == 0) begin
                  v_ff[k] <= req_tvalid;
               end else begin
                  v_ff[k] <= v_ff[(k == 0) ? 0 : k-1];
               end
            end
         end
      end
   endgenerate

   assign req_tready = en[0];

   // stage 0: alpha times opacity
   nmac_pkg::rgb_type s0_tc_ff, s0_bc_ff;
   logic [15:0] s0_ba_ff, s0_meff_ff;
   logic [31:0] s0_p_ff;
   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_p_ff    <= {16'd0, req_tdata[127:112]} * {16'd0, opacity_ff};
         s0_meff_ff <= use_mask_ff ? req_tdata[143:128] : nmac_pkg::Unit;
         s0_bc_ff   <= req_tdata[47:0];
         s0_ba_ff   <= req_tdata[63:48];
         s0_tc_ff   <= req_tdata[111:64];
      end
   end

   // stage 1: times mask, add rounding half
   nmac_pkg::rgb_type s1_tc_ff, s1_bc_ff;
   logic [15:0] s1_ba_ff;
   logic [47:0] s1_y_ff;
   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_y_ff  <= {16'd0, s0_p_ff} * {32'd0, s0_meff_ff} + nmac_pkg::HalfMm;
         s1_tc_ff <= s0_tc_ff;
         s1_bc_ff <= s0_bc_ff;
         s1_ba_ff <= s0_ba_ff;
      end
   end

   // stage 2 and 3: divide by unit squared in two steps
   nmac_pkg::rgb_type s2_tc_ff, s2_bc_ff, s3_tc_ff, s3_bc_ff;
   logic [15:0] s2_ba_ff, s3_ba_ff, s3_a_ff;
   logic [33:0] s2_z_ff, s3_q;
   assign s3_q = nmac_pkg::div_m({16'd0, s2_z_ff});
   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_z_ff  <= nmac_pkg::div_m({2'd0, s1_y_ff});
         s2_tc_ff <= s1_tc_ff;
         s2_bc_ff <= s1_bc_ff;
         s2_ba_ff <= s1_ba_ff;
      end
      if (en[3]) begin
         s3_a_ff  <= s3_q[15:0];
         s3_tc_ff <= s2_tc_ff;
         s3_bc_ff <= s2_bc_ff;
         s3_ba_ff <= s2_ba_ff;
      end
   end

   // stage 4: colour and alpha products
   nmac_pkg::rgb_type s4_bc_ff;
   logic [2:0][31:0] s4_tca_ff;
   logic [31:0] s4_bma_ff;
   logic [15:0] s4_a_ff;
   always_ff @(posedge clock) begin
      if (en[4]) begin
         for (int i = 0; i < 3; i++) begin
            s4_tca_ff[i] <= {16'd0, s3_tc_ff[i]} * {16'd0, s3_a_ff};
         end
         s4_bma_ff <= {16'd0, s3_ba_ff} * {16'd0, nmac_pkg::Unit - s3_a_ff};
         s4_a_ff   <= s3_a_ff;
         s4_bc_ff  <= s3_bc_ff;
      end
   end

   // stage 5: denominator and numerator terms
   nmac_pkg::rgb_type s5_bc_ff;
   logic [2:0][47:0] s5_tcm_ff, s5_bcb_ff;
   logic [32:0] s5_d_in;
   logic [31:0] s5_d_ff;
   assign s5_d_in = {1'b0, s4_a_ff, 16'd0} - {17'd0, s4_a_ff} + {1'b0, s4_bma_ff};
   always_ff @(posedge clock) begin
      if (en[5]) begin
         for (int i = 0; i < 3; i++) begin
            s5_tcm_ff[i] <= {s4_tca_ff[i], 16'd0} - {16'd0, s4_tca_ff[i]};
            s5_bcb_ff[i] <= {32'd0, s4_bc_ff[i]} * {16'd0, s4_bma_ff};
         end
         s5_d_ff  <= s5_d_in[31:0];
         s5_bc_ff <= s4_bc_ff;
      end
   end

   // stage 6: divider operands and output alpha
   nmac_pkg::rgb_type s6_bc_ff;
   logic [2:0][NW-1:0] s6_n_ff;
   logic [DW-1:0] s6_dv_ff;
   logic [15:0] s6_alpha_ff;
   logic        s6_zero_ff;
   logic [33:0] s6_aq;
   assign s6_aq = nmac_pkg::div_m({18'd0, s5_d_ff} + 50'd32767);
   always_ff @(posedge clock) begin
      if (en[6]) begin
         for (int i = 0; i < 3; i++) begin
            s6_n_ff[i] <= {1'b0, s5_tcm_ff[i] + s5_bcb_ff[i], 1'b0} + {18'd0, s5_d_ff};
         end
         s6_dv_ff    <= {s5_d_ff, 1'b0};
         s6_alpha_ff <= s6_aq[15:0];
         s6_zero_ff  <= (s5_d_ff == 32'd0);
         s6_bc_ff    <= s5_bc_ff;
      end
   end

   // restoring divider, one quotient bit per stage
   logic [QW-1:0][2:0][NW-1:0] dr_ff;
   logic [QW-1:0][2:0][QW-1:0] dq_ff;
   logic [QW-1:0][DW-1:0]      ddv_ff;
   logic [QW-1:0][15:0]        dal_ff;
   logic [QW-1:0]              dz_ff;
   nmac_pkg::rgb_type          dbc_ff [QW];

   genvar j;
   generate
      for (j = 0; j < QW; j++) begin : g_div
         logic [2:0][NW-1:0] r_src;
         logic [2:0][QW-1:0] q_src;
         logic [DW-1:0]      dv_src;
         logic [15:0]        al_src;
         logic               z_src;
         nmac_pkg::rgb_type  bc_src;
         logic [NW-1:0]      sh;
         if (j == 0) begin : g_first
            assign r_src  = s6_n_ff;
            assign q_src  = '0;
            assign dv_src = s6_dv_ff;
            assign al_src = s6_alpha_ff;
            assign z_src  = s6_zero_ff;
            assign bc_src = s6_bc_ff;
         end else begin : g_next
            assign r_src  = dr_ff[j-1];
            assign q_src  = dq_ff[j-1];
            assign dv_src = ddv_ff[j-1];
            assign al_src = dal_ff[j-1];
            assign z_src  = dz_ff[j-1];
            assign bc_src = dbc_ff[j-1];
         end
         assign sh = {{(NW-DW){1'b0}}, dv_src} << (QW-1-j);
         always_ff @(posedge clock) begin
            if (en[FN+j]) begin
               for (int i = 0; i < 3; i++) begin
                  if (r_src[i] >= sh) begin
                     dr_ff[j][i] <= r_src[i] - sh;
                     dq_ff[j][i] <= {q_src[i][QW-2:0], 1'b1};
                  end else begin
                     dr_ff[j][i] <= r_src[i];
                     dq_ff[j][i] <= {q_src[i][QW-2:0], 1'b0};
                  end
               end
               ddv_ff[j] <= dv_src;
               dal_ff[j] <= al_src;
               dz_ff[j]  <= z_src;
               dbc_ff[j] <= bc_src;
            end
         end
      end
   endgenerate

   // output register
   logic [63:0] out_ff;
   logic        out_zero_ff;
   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         for (int i = 0; i < 3; i++) begin
            if (dz_ff[QW-1]) begin
               out_ff[16*i +: 16] <= dbc_ff[QW-1][i];
            end else if (dq_ff[QW-1][i][QW-1]) begin
               out_ff[16*i +: 16] <= nmac_pkg::Unit;
            end else begin
               out_ff[16*i +: 16] <= dq_ff[QW-1][i][15:0];
            end
         end
         out_ff[63:48] <= dz_ff[QW-1] ? 16'd0 : dal_ff[QW-1];
         out_zero_ff   <= dz_ff[QW-1];
      end
   end

   assign rsp_tvalid = v_ff[NS-1];
   assign rsp_tdata  = out_ff;

`ifndef SYNTHESIS
   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> ((&v_ff) && !rsp_tready))
      else $error("input held back with room in the pipeline");
   a_zero_alpha: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_zero_ff) |-> (rsp_tdata[63:48] == 16'd0))
      else $error("zero coverage pixel with nonzero alpha");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (v_ff == '0))
      else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the straight-alpha over compositing pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tb;

   typedef struct packed {
      logic [15:0] mask;
      logic [15:0] ta, tb_, tg, tr;
      logic [15:0] ba, bb, bg, br;
   } pixel_pair_type;

   typedef struct packed {
      logic [15:0] a, b, g, r;
   } pixel_type;

   class composite_board;
      pixel_type   pending[$];
      logic [15:0] opacity;
      logic        use_mask;
      int          mismatches;

      function new();
         opacity    = 16'hFFFF;
         use_mask   = 1'b0;
         mismatches = 0;
      endfunction

      function automatic logic [15:0] blend(logic [15:0] t, logic [15:0] bc,
                                            logic [63:0] a, logic [63:0] b,
                                            logic [63:0] d);
         logic [63:0] num, q;
         num = 64'(t) * a * 64'd65535 + 64'(bc) * b * (64'd65535 - a);
         q   = (64'd2 * num + d) / (64'd2 * d);
         return (q > 64'd65535) ? 16'hFFFF : q[15:0];
      endfunction

      function void note_pixel(pixel_pair_type p);
         logic [63:0] a, b, d, mm, al;
         pixel_type   e;
         mm = 64'd65535 * 64'd65535;
         if (use_mask)
            a = (64'(p.ta) * 64'(opacity) * 64'(p.mask) + (mm - 64'd1) / 64'd2) / mm;
         else
            a = (64'(p.ta) * 64'(opacity) + 64'd32767) / 64'd65535;
         if (a > 64'd65535) a = 64'd65535;
         b = 64'(p.ba);
         d = a * 64'd65535 + b * (64'd65535 - a);
         if (d == 64'd0) begin
            e = '{a: 16'd0, b: p.bb, g: p.bg, r: p.br};
         end else begin
            e.r = blend(p.tr, p.br, a, b, d);
            e.g = blend(p.tg, p.bg, a, b, d);
            e.b = blend(p.tb_, p.bb, a, b, d);
            al  = (d + 64'd32767) / 64'd65535;
            e.a = (al > 64'd65535) ? 16'hFFFF : al[15:0];
         end
         pending.push_back(e);
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pixel %h", got);
            return;
         end
         e = pending.pop_front();
         if (got.r !== e.r || got.g !== e.g || got.b !== e.b || got.a !== e.a) begin
            mismatches++;
            if (mismatches <= 10)
               $display("pixel mismatch: expected r%h g%h b%h a%h got r%h g%h b%h a%h",
                        e.r, e.g, e.b, e.a, got.r, got.g, got.b, got.a);
         end
      endfunction
   endclass

   logic         clock, reset;
   logic         req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [143:0] req_tdata;
   logic [63:0]  rsp_tdata;
   logic         csr_valid, csr_ready;
   logic [7:0]   csr_index;
   logic [15:0]  csr_data;

   composite_board board;
   int  idle_cycles;
   bit  hold_off;
   bit  rsp_random;

   normal_mode_alpha_composite_top uut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // receiver: stall pattern, with long hold-off on request
   initial begin
      int k;
      rsp_tready = 0;
      k = 0;
      forever begin
         @(posedge clock);
         k++;
         if (hold_off) rsp_tready <= 1'b0;
         else if (!rsp_random) rsp_tready <= 1'b1;
         else rsp_tready <= ((k % 7) < 4) || ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_pixel(rsp_tdata);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles > 5000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_reg(nmac_pkg::reg_index_type idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == nmac_pkg::REG_OPACITY) board.opacity = val;
      else if (idx == nmac_pkg::REG_USE_MASK) board.use_mask = val[0];
   endtask

   task automatic send_pixel(pixel_pair_type p);
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      do @(posedge clock); while (!req_tready);
      board.note_pixel(p);
   endtask

   task automatic pause_sender();
      req_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 3));
         3: return 16'hFFFF - 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic pixel_pair_type random_pixel();
      pixel_pair_type p;
      p = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
      p.ta   = pick16();
      p.ba   = pick16();
      p.mask = pick16();
      if ($urandom_range(0, 7) == 0) begin
         p.ta = 0;
         p.ba = 0;
      end
      return p;
   endfunction

   task automatic random_burst(int n);
      int left, burst;
      left = n;
      while (left > 0) begin
         burst = $urandom_range(1, 20);
         if (burst > left) burst = left;
         repeat (burst) send_pixel(random_pixel());
         left -= burst;
         if ($urandom_range(0, 2) != 0) pause_sender();
      end
   endtask

   initial begin
      pixel_pair_type p;
      board      = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = nmac_pkg::REG_OPACITY;
      csr_data   = '0;
      hold_off   = 1'b0;
      rsp_random = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, both alphas zero, opaque top, opaque bottom
      p = '0;                   send_pixel(p);
      p = '1;                   send_pixel(p);
      p = '0; p.br = 16'h1234; p.bg = 16'hFFFF; p.bb = 16'h0001; send_pixel(p);
      p = '1; p.ta = 0;         send_pixel(p);
      p = '1; p.ba = 0;         send_pixel(p);
      p = '0; p.ta = 16'hFFFF; p.tr = 16'hFFFF; send_pixel(p);
      p = '1; p.ta = 1; p.ba = 1; send_pixel(p);
      p = {16'h8000, 16'h8000, 16'hAAAA, 16'h5555, 16'hFFFF,
           16'h7FFF, 16'h0000, 16'hFFFF, 16'h8001};
      send_pixel(p);
      drain();

      write_reg(nmac_pkg::REG_USE_MASK, 16'd1);
      p = '1; p.mask = 0;       send_pixel(p);
      p = '1;                   send_pixel(p);
      p = '1; p.mask = 1; p.ba = 0; send_pixel(p);
      p = random_pixel();       send_pixel(p);
      drain();
      write_reg(nmac_pkg::REG_OPACITY, 16'd0);
      p = '1; p.ba = 0;         send_pixel(p);
      drain();

      // random phases across register settings
      rsp_random = 1'b1;
      write_reg(nmac_pkg::REG_USE_MASK, 16'd0);
      write_reg(nmac_pkg::REG_OPACITY, 16'hFFFF);
      random_burst(150);
      drain();
      write_reg(nmac_pkg::REG_OPACITY, 16'd0);
      random_burst(60);
      drain();
      write_reg(nmac_pkg::REG_OPACITY, 16'd1);
      write_reg(nmac_pkg::REG_USE_MASK, 16'hFFFE);
      random_burst(60);
      drain();
      write_reg(nmac_pkg::REG_OPACITY, 16'h8000);
      write_reg(nmac_pkg::REG_USE_MASK, 16'd1);
      random_burst(150);
      drain();

      // receiver holds off while the sender keeps offering
      fork
         begin
            hold_off = 1'b1;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         repeat (60) send_pixel(random_pixel());
      join
      drain();

      write_reg(nmac_pkg::REG_OPACITY, 16'($urandom));
      write_reg(nmac_pkg::REG_USE_MASK, 16'($urandom_range(0, 1)));
      random_burst(200);
      drain();

      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
